// File: rtl/stb_pkg.sv
// Shared types and constants for the software timer bank.
// No dependencies; every other file of the block but stb_if imports this package.
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

    // Default number of timers and the firing limit per tick
    localparam int unsigned TIMERS_DEF  = 32;
    localparam int unsigned MAX_RESULTS = 32;
    localparam int unsigned FIRE_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] NO_DEADLINE = 32'hFFFF_FFFF;

    // Request codes on the input channel
    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_ALLOC = 3'd1,
        KIND_FREE  = 3'd2,
        KIND_EVENT = 3'd3,
        KIND_TIME  = 3'd4
    } t_kind;

    // Result codes on the output channel
    typedef enum logic {
        RES_ALLOC = 1'b0,
        RES_FIRED = 1'b1
    } t_res_kind;

    // Timer status
    typedef enum logic [1:0] {
        ST_UNUSED = 2'd0,
        ST_ALLOC  = 2'd1,
        ST_ARMED  = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_FLUSH = 2'd2
    } t_state;

    // State of one timer, held in one ring cell
    typedef struct packed {
        t_status     status;
        logic [31:0] deadline;
        logic [3:0]  queue;
        logic [7:0]  payload;
    } t_entry;

    // Control from the sequencer to the head unit
    typedef struct packed {
        t_kind       op;
        logic        sel;       // entry at the head is the addressed timer
        logic [31:0] count;     // tick count after the increment
        logic [31:0] arg;       // absolute deadline for set time
        logic [3:0]  qid;
        logic [7:0]  data;
        logic        room;      // firing limit not reached yet
        logic        claimed;   // alloc already found a timer
    } t_head_ctl;

    // Status from the head unit back to the sequencer
    typedef struct packed {
        t_entry entry;          // updated entry, written to the ring tail
        logic   fire;
        logic   claim;
        logic   keep;           // still armed after this pass
    } t_head_res;

    // One result word
    typedef struct packed {
        t_res_kind   result_kind;
        logic [4:0]  slot;
        logic        granted;
        logic [3:0]  dest_queue;
        logic [7:0]  payload;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/stb_if.sv
// Valid/ready channel interfaces of the software timer bank.
// Standalone; used by the top level ports.
`timescale 1ns / 1ps
`default_nettype none

interface stb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [4:0]  timer_index;
    logic [3:0]  queue_id;
    logic [7:0]  event_data;
    logic [31:0] delay;

    modport source (output valid, kind, timer_index, queue_id, event_data, delay,
                    input ready);
    modport sink   (input valid, kind, timer_index, queue_id, event_data, delay,
                    output ready);
endinterface

interface stb_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [4:0]  slot;
    logic        granted;
    logic [3:0]  dest_queue;
    logic [7:0]  payload;
    logic        last;

    modport source (output valid, result_kind, slot, granted, dest_queue, payload,
                    last, input ready);
    modport sink   (input valid, result_kind, slot, granted, dest_queue, payload,
                    last, output ready);
endinterface

`default_nettype wire

// File: rtl/stb_cell.sv
// One ring cell: holds the state of one timer and shifts it to its neighbor.
// Depends on stb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stb_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_shift,
    input  wire stb_pkg::t_entry i_entry,
    output stb_pkg::t_entry     o_entry
);
    import stb_pkg::*;

    t_status     r_status;
    logic [31:0] r_deadline;
    logic [3:0]  r_queue;
    logic [7:0]  r_payload;

    // Status, queue and data reset to an unused, zeroed timer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= ST_UNUSED;
            r_queue   <= '0;
            r_payload <= '0;
        end else if (i_shift) begin
            r_status  <= i_entry.status;
            r_queue   <= i_entry.queue;
            r_payload <= i_entry.payload;
        end
    end

    // Deadline is only read while armed, so it needs no reset
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_deadline <= i_entry.deadline;
        end
    end

    assign o_entry = '{status: r_status, deadline: r_deadline,
                       queue: r_queue, payload: r_payload};

endmodule

`default_nettype wire

// File: rtl/stb_head.sv
// Head unit: updates the timer entry leaving the ring head for the current request.
// Depends on stb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stb_head (
    input  wire stb_pkg::t_entry    i_entry,
    input  wire stb_pkg::t_head_ctl i_ctl,
    output stb_pkg::t_head_res      o_res
);
    import stb_pkg::*;

    logic armed;
    logic due;

    assign armed = (i_entry.status == ST_ARMED);
    assign due   = (i_entry.deadline <= i_ctl.count);

    always_comb begin
        o_res.entry = i_entry;
        o_res.fire  = 1'b0;
        o_res.claim = 1'b0;
        o_res.keep  = 1'b0;
        unique case (i_ctl.op)
            KIND_TICK: begin
                // Fire due timers up to the limit, keep the rest armed
                o_res.fire = armed && due && i_ctl.room;
                o_res.keep = armed && !o_res.fire;
                if (o_res.fire) begin
                    o_res.entry.status = ST_ALLOC;
                end
            end
            KIND_ALLOC: begin
                // Claim the first unused timer of the pass
                o_res.claim = (i_entry.status == ST_UNUSED) && !i_ctl.claimed;
                if (o_res.claim) begin
                    o_res.entry.status = ST_ALLOC;
                end
            end
            KIND_FREE: begin
                if (i_ctl.sel) begin
                    o_res.entry.status = ST_UNUSED;
                end
            end
            KIND_EVENT: begin
                if (i_ctl.sel) begin
                    o_res.entry.queue   = i_ctl.qid;
                    o_res.entry.payload = i_ctl.data;
                end
            end
            KIND_TIME: begin
                if (i_ctl.sel) begin
                    o_res.entry.deadline = i_ctl.arg;
                    o_res.entry.status   = ST_ARMED;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/software_timer_bank_top.sv
// Software timer bank: bank of one-shot timers on a 32-bit tick count.
// Depends on stb_pkg, stb_if, stb_cell and stb_head.
//
// Usage:
//   i_in carries one request word: tick, alloc, free, set event or set time.
//   o_out carries result words: alloc replies and fired timers; the final word
//   caused by a request has last set.
// Timing:
//   A tick before the cached earliest deadline, an unused kind, or a free/set
//   request with timer_index >= TIMERS needs no ring pass and gives no word.
//   Every other request makes one pass over the ring: the timer entries sit in a
//   ring of TIMERS cells that rotates one cell per cycle, unless stalled, past
//   a single head unit, then a flush state delivers the pending word. Alloc
//   replies are loaded into the output register in the flush state.
//   A fired timer is held back one position so that last can be set on the
//   final one; each further firing needs the output register free, so a
//   stalled receiver stops the ring rotation until the word is taken.
//   i_in.ready is high only between requests; the output register lets the
//   next request enter while the last word still waits.
// Reset: synchronous, active low. All timers unused, tick count zero, cached
//   deadline all ones, no word pending; i_in.ready stays low while in reset.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_bank_top #(
    parameter int unsigned TIMERS = stb_pkg::TIMERS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stb_in_if.sink     i_in,
    stb_out_if.source  o_out
);
    import stb_pkg::*;

    localparam int unsigned IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    // Sequencer and request registers
    t_state        r_state;
    t_state        n_state;
    t_kind         r_op;
    logic [4:0]    r_idx;
    logic [3:0]    r_qid;
    logic [7:0]    r_data;
    logic [31:0]   r_arg;
    logic [31:0]   r_count;
    logic [31:0]   r_earliest;
    logic [IW-1:0] r_cnt;
    logic [FIRE_W-1:0] r_nfire;
    logic          r_pend_valid;
    t_result       r_pend;
    logic          r_out_valid;
    t_result       r_out;
    logic          r_out_last;

    // Decode of the incoming word
    logic          accept;
    logic          go_scan;
    logic          idx_ok;
    logic [31:0]   next_count;
    logic [31:0]   set_deadline;

    // FSM outputs
    logic          in_ready;
    logic          adv;
    logic          out_load;
    logic          load_last;
    logic          out_free;
    logic          cnt_last;

    // Ring and head unit
    t_entry        w_cell [TIMERS];
    t_head_ctl     head_ctl;
    t_head_res     head_res;

    assign accept       = i_in.valid && in_ready && i_rst_n;
    assign idx_ok       = (7'(i_in.timer_index) < 7'(TIMERS));
    assign next_count   = r_count + 32'd1;
    assign set_deadline = i_in.delay + r_count;
    assign out_free     = !r_out_valid || o_out.ready;
    assign cnt_last     = (r_cnt == IW'(TIMERS - 1));

    // Decide whether the request needs a pass over the ring
    always_comb begin
        go_scan = 1'b0;
        unique case (i_in.kind)
            KIND_TICK:  go_scan = !(r_earliest > next_count);
            KIND_ALLOC: go_scan = 1'b1;
            KIND_FREE,
            KIND_EVENT,
            KIND_TIME:  go_scan = idx_ok;
            default:    go_scan = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && go_scan) n_state = S_SCAN;
            S_SCAN:  if (adv && cnt_last) n_state = S_FLUSH;
            S_FLUSH: if (!r_pend_valid || out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        in_ready  = 1'b0;
        adv       = 1'b0;
        out_load  = 1'b0;
        load_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_SCAN: begin
                // A new firing pushes the held word out, which needs room
                adv      = !(head_res.fire && r_pend_valid) || out_free;
                out_load = head_res.fire && r_pend_valid && out_free;
            end
            S_FLUSH: begin
                out_load  = r_pend_valid && out_free;
                load_last = 1'b1;
            end
            default: ;
        endcase
    end

    // Head unit control
    assign head_ctl = '{op: r_op,
                        sel: (7'(r_idx) == 7'(r_cnt)),
                        count: r_count,
                        arg: r_arg,
                        qid: r_qid,
                        data: r_data,
                        room: (r_nfire < FIRE_W'(MAX_RESULTS)),
                        claimed: r_pend.granted};

    stb_head u_head (
        .i_entry (w_cell[0]),
        .i_ctl   (head_ctl),
        .o_res   (head_res)
    );

    // Ring of timer cells: each takes its neighbor, the tail takes the head result
    for (genvar gi = 0; gi < TIMERS; gi++) begin : g_ring
        t_entry cell_in;
        if (gi == TIMERS - 1) begin : g_tail
            assign cell_in = head_res.entry;
        end else begin : g_mid
            assign cell_in = w_cell[gi + 1];
        end
        stb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (adv),
            .i_entry (cell_in),
            .o_entry (w_cell[gi])
        );
    end

    // Sequencer, deadline cache and pending word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= KIND_TICK;
            r_idx        <= '0;
            r_qid        <= '0;
            r_data       <= '0;
            r_arg        <= '0;
            r_count      <= '0;
            r_earliest   <= NO_DEADLINE;
            r_cnt        <= '0;
            r_nfire      <= '0;
            r_pend_valid <= 1'b0;
            r_pend       <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_op    <= t_kind'(i_in.kind);
                r_idx   <= i_in.timer_index;
                r_qid   <= i_in.queue_id;
                r_data  <= i_in.event_data;
                r_arg   <= set_deadline;
                r_cnt   <= '0;
                r_nfire <= '0;
                r_pend  <= '{result_kind: RES_ALLOC, slot: 5'd0, granted: 1'b0,
                             dest_queue: 4'd0, payload: 8'd0};
                r_pend_valid <= (i_in.kind == KIND_ALLOC);
                if (i_in.kind == KIND_TICK) begin
                    r_count <= next_count;
                    if (go_scan) begin
                        r_earliest <= NO_DEADLINE;
                    end
                end else if (i_in.kind == KIND_TIME && idx_ok) begin
                    if (r_earliest > set_deadline) begin
                        r_earliest <= set_deadline;
                    end
                end
            end
            if (adv) begin
                r_cnt <= cnt_last ? '0 : r_cnt + IW'(1);
                // Recompute the earliest deadline from timers left armed
                if (head_res.keep && (w_cell[0].deadline < r_earliest)) begin
                    r_earliest <= w_cell[0].deadline;
                end
                // Hold the newest firing until the next one or the end of the pass
                if (head_res.fire) begin
                    r_pend_valid <= 1'b1;
                    r_nfire      <= r_nfire + FIRE_W'(1);
                    r_pend       <= '{result_kind: RES_FIRED, slot: 5'(r_cnt),
                                      granted: 1'b0, dest_queue: w_cell[0].queue,
                                      payload: w_cell[0].payload};
                end
                if (head_res.claim) begin
                    r_pend.slot    <= 5'(r_cnt);
                    r_pend.granted <= 1'b1;
                end
            end
            if (r_state == S_FLUSH && n_state == S_IDLE) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out      <= r_pend;
            r_out_last <= load_last;
        end
    end

    assign i_in.ready        = in_ready && i_rst_n;
    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out.result_kind;
    assign o_out.slot        = r_out.slot;
    assign o_out.granted     = r_out.granted;
    assign o_out.dest_queue  = r_out.dest_queue;
    assign o_out.payload     = r_out.payload;
    assign o_out.last        = r_out_last;

    // The ring is back in place whenever no pass runs
    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("ring not aligned at idle");

    // No word is left pending once a request is finished
    a_no_stale_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending word left at idle");

    // Firings per tick stay within the limit
    a_fire_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfire <= FIRE_W'(MAX_RESULTS)))
        else $error("firing limit exceeded");

    // A fired word never carries a grant
    a_fired_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.result_kind == RES_FIRED)) |-> !r_out.granted)
        else $error("fired word carries a grant");

endmodule

`default_nettype wire

// File: tb/tb_software_timer_bank_top.sv
// Testbench for software_timer_bank_top: directed and random request words,
// checked word by word against a scoreboard that keeps its own timer bank.
// Depends on stb_pkg, the stb_in_if / stb_out_if interfaces and software_timer_bank_top.
`timescale 1ns / 1ps

import stb_pkg::*;

// One request word as accepted on the input channel
typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  index;
    logic [3:0]  qid;
    logic [7:0]  data;
    logic [31:0] delay;
} t_timer_req;

// One result word with its end-of-request flag
typedef struct packed {
    t_result res;
    logic    last;
} t_timer_word;

// Shadow timer bank: predicts the result words of each accepted request
class timer_bank_scoreboard;
    t_status     status_of [TIMERS_DEF];
    logic [31:0] due_at    [TIMERS_DEF];
    logic [3:0]  queue_of  [TIMERS_DEF];
    logic [7:0]  byte_of   [TIMERS_DEF];
    logic [31:0] tick_count;
    logic [31:0] next_due;
    t_timer_word awaited_words [$];
    int          mismatches;
    bit          grant_ok;
    logic [4:0]  grant_slot;

    function new();
        tick_count = '0;
        next_due   = NO_DEADLINE;
        mismatches = 0;
        grant_ok   = 1'b0;
        grant_slot = '0;
        for (int i = 0; i < TIMERS_DEF; i++) begin
            status_of[i] = ST_UNUSED;
            due_at[i]    = '0;
            queue_of[i]  = '0;
            byte_of[i]   = '0;
        end
    endfunction

    function int unused_count();
        int n;
        n = 0;
        for (int i = 0; i < TIMERS_DEF; i++)
            if (status_of[i] == ST_UNUSED) n++;
        return n;
    endfunction

    // Update the bank for one accepted request and queue the words it causes
    function void note_request(t_timer_req r);
        t_timer_word w;
        int          fired;
        logic [31:0] due;
        case (r.kind)
            KIND_TICK: begin
                tick_count = tick_count + 32'd1;
                // Before the cached deadline nothing can be due
                if (next_due <= tick_count) begin
                    next_due = NO_DEADLINE;
                    fired    = 0;
                    for (int i = 0; i < TIMERS_DEF; i++) begin
                        if (status_of[i] == ST_ARMED) begin
                            if (due_at[i] <= tick_count && fired < MAX_RESULTS) begin
                                status_of[i]         = ST_ALLOC;
                                w                    = '0;
                                w.res.result_kind    = RES_FIRED;
                                w.res.slot           = 5'(i);
                                w.res.dest_queue     = queue_of[i];
                                w.res.payload        = byte_of[i];
                                awaited_words.push_back(w);
                                fired++;
                            end else if (next_due > due_at[i]) begin
                                next_due = due_at[i];
                            end
                        end
                    end
                    if (fired > 0)
                        awaited_words[awaited_words.size() - 1].last = 1'b1;
                end
            end
            KIND_ALLOC: begin
                grant_ok   = 1'b0;
                grant_slot = '0;
                for (int i = 0; i < TIMERS_DEF && !grant_ok; i++) begin
                    if (status_of[i] == ST_UNUSED) begin
                        status_of[i] = ST_ALLOC;
                        grant_ok     = 1'b1;
                        grant_slot   = 5'(i);
                    end
                end
                w                 = '0;
                w.res.result_kind = RES_ALLOC;
                w.res.slot        = grant_slot;
                w.res.granted     = grant_ok;
                w.last            = 1'b1;
                awaited_words.push_back(w);
            end
            KIND_FREE: begin
                if (r.index < TIMERS_DEF) status_of[r.index] = ST_UNUSED;
            end
            KIND_EVENT: begin
                if (r.index < TIMERS_DEF) begin
                    queue_of[r.index] = r.qid;
                    byte_of[r.index]  = r.data;
                end
            end
            KIND_TIME: begin
                if (r.index < TIMERS_DEF) begin
                    // Deadline wraps mod 2^32, compared without wrap handling
                    due                = r.delay + tick_count;
                    due_at[r.index]    = due;
                    status_of[r.index] = ST_ARMED;
                    if (next_due > due) next_due = due;
                end
            end
            default: ;
        endcase
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_word(t_timer_word got);
        t_timer_word exp;
        bit          bad;
        if (awaited_words.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: unexpected word kind=%0d slot=%0d granted=%0d queue=%0d",
                         $time, got.res.result_kind, got.res.slot, got.res.granted,
                         got.res.dest_queue);
            mismatches++;
            return;
        end
        exp = awaited_words.pop_front();
        bad = (got.res.result_kind != exp.res.result_kind) ||
              (got.res.slot        != exp.res.slot)        ||
              (got.res.granted     != exp.res.granted)     ||
              (got.res.dest_queue  != exp.res.dest_queue)  ||
              (got.res.payload     != exp.res.payload)     ||
              (got.last            != exp.last);
        if (bad) begin
            if (mismatches < 10) begin
                $write("%0t: word mismatch: expected kind=%0d slot=%0d granted=%0d ",
                       $time, exp.res.result_kind, exp.res.slot, exp.res.granted);
                $write("queue=%0d payload=%0h last=%0d, ",
                       exp.res.dest_queue, exp.res.payload, exp.last);
                $display("got kind=%0d slot=%0d granted=%0d queue=%0d payload=%0h last=%0d",
                         got.res.result_kind, got.res.slot, got.res.granted,
                         got.res.dest_queue, got.res.payload, got.last);
            end
            mismatches++;
        end
    endfunction
endclass

module tb_software_timer_bank_top;

    // Request codes the block ignores
    localparam logic [2:0] KIND_RSVD5 = 3'd5;
    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;

    localparam int QUIET_LIMIT = 2000;
    localparam int ITEM_TARGET = 220;
    localparam int CALM_FROM   = 185;

    logic clk;
    logic rst_n;

    stb_in_if  req_if ();
    stb_out_if rsp_if ();

    timer_bank_scoreboard board;

    int counted      = 0;
    int sends        = 0;
    int src_gap_pct  = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;

    software_timer_bank_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 20;
            default: return 50;
        endcase
    endfunction

    // Mostly short delays so timers fire within the run; some huge or wrapping
    function automatic logic [31:0] pick_delay();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65) return 32'($urandom_range(0, 8));
        if (roll < 82) return 32'($urandom_range(9, 64));
        if (roll < 92) return $urandom();
        return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    endfunction

    // Present one word, hold it until accepted, then note it in the scoreboard
    task automatic send_request(input logic [2:0] kind, input logic [4:0] index,
                                input logic [3:0] qid, input logic [7:0] data,
                                input logic [31:0] delay);
        t_timer_req r;
        r = '{kind, index, qid, data, delay};
        if (sends % 30 == 0) src_gap_pct = pick_pct();
        sends++;
        if (!calm && $urandom_range(99) < src_gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= kind;
        req_if.timer_index <= index;
        req_if.queue_id    <= qid;
        req_if.event_data  <= data;
        req_if.delay       <= delay;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        board.note_request(r);
        if (kind <= KIND_TIME) counted++;
    endtask

    task automatic run_ticks(input int n);
        repeat (n)
            send_request(KIND_TICK, 5'($urandom()), 4'($urandom()), 8'($urandom()),
                         $urandom());
    endtask

    task automatic send_alloc();
        send_request(KIND_ALLOC, 5'($urandom()), 4'($urandom()), 8'($urandom()),
                     $urandom());
    endtask

    // Count cycles with no word moving on either side
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Check every accepted result word
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            board.check_word(t_timer_word'({rsp_if.result_kind, rsp_if.slot,
                                            rsp_if.granted, rsp_if.dest_queue,
                                            rsp_if.payload, rsp_if.last}));
    end

    // Receiver: stall in random bursts, with calm stretches
    initial begin : sink_side
        int stall_left;
        int stall_pct;
        int cycle_no;
        stall_left   = 0;
        stall_pct    = 0;
        cycle_no     = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no % 50 == 0) stall_pct = pick_pct();
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(99) < stall_pct) begin
                rsp_if.ready <= 1'b0;
                stall_left = $urandom_range(3);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: give up when nothing moves for too long
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int         roll;
        logic [4:0] slot;
        board              = new();
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.kind        = '0;
        req_if.timer_index = '0;
        req_if.queue_id    = '0;
        req_if.event_data  = '0;
        req_if.delay       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fire on delay zero, then a plain tick with nothing cached
        send_alloc();
        send_request(KIND_EVENT, 5'd0, 4'hF, 8'hFF, 32'd0);
        send_request(KIND_TIME, 5'd0, 4'd0, 8'd0, 32'd0);
        run_ticks(2);
        // Free an armed timer: the cached deadline stays, so a tick only rescans
        send_request(KIND_TIME, 5'd7, 4'hF, 8'hFF, 32'd2);
        send_request(KIND_FREE, 5'd7, 4'd0, 8'd0, 32'hFFFF_FFFF);
        run_ticks(2);
        // Two fire on one tick; the top one arms an unused timer with a wrapped deadline
        send_request(KIND_EVENT, 5'd5, 4'hA, 8'hA5, 32'd0);
        send_request(KIND_TIME, 5'd5, 4'd0, 8'd0, 32'd1);
        send_request(KIND_TIME, 5'd31, 4'd0, 8'd0, 32'hFFFF_FFFF);
        send_request(KIND_EVENT, 5'd31, 4'h1, 8'h5A, 32'd0);
        run_ticks(1);
        send_alloc();
        // Huge deadlines stay armed
        send_request(KIND_TIME, 5'd2, 4'd0, 8'd0, $urandom());
        send_request(KIND_TIME, 5'd2, 4'd0, 8'd0, 32'h8000_0000);
        // Ignored kinds
        send_request(KIND_RSVD5, 5'd31, 4'hF, 8'hFF, 32'hFFFF_FFFF);
        send_request(KIND_RSVD6, 5'($urandom()), 4'($urandom()), 8'($urandom()), $urandom());
        send_request(KIND_RSVD7, 5'd0, 4'd0, 8'd0, 32'd0);
        send_request(KIND_FREE, 5'd31, 4'd0, 8'd0, 32'd0);
        send_alloc();
        run_ticks(1);

        // Random: mostly alloc / program / wait sequences, plus noise
        while (counted < ITEM_TARGET) begin
            calm = (counted >= CALM_FROM);
            roll = $urandom_range(99);
            if (roll < 35) begin
                // claim a timer, program it and let it run out
                send_alloc();
                slot = board.grant_ok ? board.grant_slot : 5'($urandom());
                send_request(KIND_EVENT, slot, 4'($urandom()), 8'($urandom()), $urandom());
                send_request(KIND_TIME, slot, 4'($urandom()), 8'($urandom()), pick_delay());
                run_ticks($urandom_range(1, 3));
            end else if (roll < 50) begin
                // arm several close together so one tick fires many
                repeat ($urandom_range(2, 6)) begin
                    slot = 5'($urandom());
                    if ($urandom_range(1))
                        send_request(KIND_EVENT, slot, 4'($urandom()), 8'($urandom()),
                                     $urandom());
                    send_request(KIND_TIME, slot, 4'($urandom()), 8'($urandom()),
                                 32'($urandom_range(0, 3)));
                end
                run_ticks($urandom_range(1, 4));
            end else if (roll < 68) begin
                repeat ($urandom_range(1, 4))
                    send_request(KIND_FREE, 5'($urandom()), 4'($urandom()),
                                 8'($urandom()), $urandom());
            end else if (roll < 73) begin
                // exhaust the bank when it is nearly full, then get refused
                if (board.unused_count() <= 10) begin
                    while (board.unused_count() > 0) send_alloc();
                    send_alloc();
                end else begin
                    repeat (3) send_alloc();
                end
            end else if (roll < 85) begin
                send_request(3'($urandom_range(7)), 5'($urandom()), 4'($urandom()),
                             8'($urandom()), $urandom());
            end else begin
                run_ticks($urandom_range(1, 6));
            end
        end
        req_if.valid <= 1'b0;

        // Drain, then allow for a word still on its way
        while (board.awaited_words.size() != 0) @(posedge clk);
        repeat (TIMERS_DEF + 8) @(posedge clk);
        if (board.awaited_words.size() != 0) begin
            $display("%0d result words never arrived", board.awaited_words.size());
            board.mismatches += board.awaited_words.size();
        end

        if (board.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
